/* hdl/sip_method_keyword_matcher_defines.svh */
// Assertion macros used by the SIP method keyword matcher checker.
`ifndef SIP_METHOD_KEYWORD_MATCHER_DEFINES_SVH
`define SIP_METHOD_KEYWORD_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define SIPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define SIPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sipm_pkg.sv */
// Package: keyword table, method codes and shared types of the SIP method matcher.
package sipm_pkg;

  localparam int KEYWORD_COUNT   = 10;
  localparam int LONGEST_KEYWORD = 9;
  localparam int KW_TEXT_W       = 8 * LONGEST_KEYWORD;

  localparam logic [3:0] COUNT_LIMIT =
    4'(((LONGEST_KEYWORD + 1) > 15) ? 15 : (LONGEST_KEYWORD + 1));
  localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;
  localparam logic [KEYWORD_COUNT-1:0] ALL_ALIVE = '1;

  typedef enum logic [3:0] {
    METHOD_GENERIC   = 4'd0,
    METHOD_ACK       = 4'd1,
    METHOD_BYE       = 4'd2,
    METHOD_CANCEL    = 4'd3,
    METHOD_INFO      = 4'd4,
    METHOD_INVITE    = 4'd5,
    METHOD_OPTIONS   = 4'd6,
    METHOD_PRACK     = 4'd7,
    METHOD_REFER     = 4'd8,
    METHOD_REGISTER  = 4'd9,
    METHOD_SUBSCRIBE = 4'd10
  } method_code_t;

  // Keyword k is method code k+1; text is right-aligned, first letter highest.
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    "ACK", "BYE", "CANCEL", "INFO", "INVITE",
    "OPTIONS", "PRACK", "REFER", "REGISTER", "SUBSCRIBE"
  };

  localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
    4'd3, 4'd3, 4'd6, 4'd4, 4'd6, 4'd7, 4'd5, 4'd5, 4'd8, 4'd9
  };

  typedef struct packed {
    logic       valid;
    logic [7:0] token_byte;
    logic       token_end;
  } byte_item_t;

  typedef struct packed {
    logic         load;
    method_code_t code;
  } match_result_t;

  // True when folded byte c equals letter pos of keyword k.
  function automatic logic kw_match(input logic [3:0] k, input logic [3:0] pos,
                                    input logic [7:0] c);
    logic [KW_TEXT_W-1:0] text;
    logic [3:0]           len;
    logic [3:0]           back;
    logic [7:0]           letter;
    text   = KW_TEXT[k];
    len    = KW_LEN[k];
    back   = len - 4'd1 - pos;
    letter = text[{back, 3'b000} +: 8];
    return (pos < len) && (letter == c);
  endfunction

endpackage

/* hdl/sip_method_keyword_matcher.sv */
// Top level of the SIP method keyword matcher.
// Takes one method token byte per cycle while token_stall is low, case-folded,
// and on the byte flagged token_end gives one method_code item (0 generic,
// 1 ACK .. 10 SUBSCRIBE) for the token that equals a keyword in length and
// letters. The final byte passes through the input register, a combinational
// per-keyword compare and the result register, which presents the code until
// it is taken. Bytes keep flowing while a result waits; only a final byte
// stalls, and only while the previous result is still held. No clearing
// pass.
module sip_method_keyword_matcher (
  input  logic       clk,
  input  logic       rst,
  input  logic       token_valid,
  output logic       token_stall,
  input  logic [7:0] token_byte,
  input  logic       token_end,
  output logic       method_valid,
  input  logic       method_stall,
  output logic [3:0] method_code
);

  sipm_pkg::byte_item_t    item;
  sipm_pkg::match_result_t result;
  logic                    advance;

  assign advance = item.valid && (!item.token_end || !method_valid || !method_stall);

  sipm_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_byte  (token_byte),
    .token_end   (token_end),
    .advance     (advance),
    .item        (item)
  );

  sipm_match u_match (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  sipm_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .method_valid (method_valid),
    .method_stall (method_stall),
    .method_code  (method_code)
  );

endmodule

/* hdl/sipm_in_reg.sv */
// Input register: holds one token byte item until the match stage takes it.
module sipm_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                token_valid,
  output logic                token_stall,
  input  logic [7:0]          token_byte,
  input  logic                token_end,
  input  logic                advance,
  output sipm_pkg::byte_item_t item
);

  logic       valid;
  logic [7:0] byte_q;
  logic       end_q;

  assign token_stall = valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (token_valid && !token_stall) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (token_valid && !token_stall) begin
      byte_q <= token_byte;
      end_q  <= token_end;
    end
  end

  assign item = '{valid: valid, token_byte: byte_q, token_end: end_q};

endmodule

/* hdl/sipm_match.sv */
// Match stage: per-keyword compare, alive bits, byte count and code select.
module sipm_match (
  input  logic                   clk,
  input  logic                   rst,
  input  sipm_pkg::byte_item_t   item,
  input  logic                   advance,
  output sipm_pkg::match_result_t result
);

  logic [3:0]                         byte_count;
  logic [3:0]                         byte_count_next;
  logic [sipm_pkg::KEYWORD_COUNT-1:0] keyword_alive;
  logic [sipm_pkg::KEYWORD_COUNT-1:0] keyword_alive_next;

  logic [7:0]                         folded;
  logic [3:0]                         count_after;
  logic [sipm_pkg::KEYWORD_COUNT-1:0] alive_after;
  sipm_pkg::method_code_t             code;

  always_comb begin
    folded = item.token_byte & sipm_pkg::CASE_FOLD_MASK;
    for (int k = 0; k < sipm_pkg::KEYWORD_COUNT; k++) begin
      alive_after[k] = keyword_alive[k] && sipm_pkg::kw_match(4'(k), byte_count, folded);
    end
    count_after = (byte_count < sipm_pkg::COUNT_LIMIT) ? byte_count + 4'd1 : byte_count;
  end

  // Lowest keyword index wins.
  always_comb begin
    code = sipm_pkg::METHOD_GENERIC;
    for (int k = sipm_pkg::KEYWORD_COUNT - 1; k >= 0; k--) begin
      if (alive_after[k] && (sipm_pkg::KW_LEN[k] == count_after)) begin
        code = sipm_pkg::method_code_t'(4'(k + 1));
      end
    end
  end

  always_comb begin
    byte_count_next    = byte_count;
    keyword_alive_next = keyword_alive;
    if (advance) begin
      if (item.token_end) begin
        byte_count_next    = 4'd0;
        keyword_alive_next = sipm_pkg::ALL_ALIVE;
      end else begin
        byte_count_next    = count_after;
        keyword_alive_next = alive_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 4'd0;
      keyword_alive <= sipm_pkg::ALL_ALIVE;
    end else begin
      byte_count    <= byte_count_next;
      keyword_alive <= keyword_alive_next;
    end
  end

  assign result = '{load: advance && item.token_end, code: code};

endmodule

/* hdl/sipm_out_reg.sv */
// Result register: holds the method code item until the consumer takes it.
module sipm_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  sipm_pkg::match_result_t result,
  output logic                    method_valid,
  input  logic                    method_stall,
  output logic [3:0]              method_code
);

  logic                   valid;
  sipm_pkg::method_code_t code_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (result.load) begin
      valid <= 1'b1;
    end else if (!method_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      code_q <= result.code;
    end
  end

  assign method_valid = valid;
  assign method_code  = code_q;

endmodule

/* hdl/sipm_checker.sv */
// Port-level checker for the SIP method keyword matcher, bound to the top level.
`include "sip_method_keyword_matcher_defines.svh"

module sipm_checker (
  input logic       clk,
  input logic       rst,
  input logic       token_valid,
  input logic       token_stall,
  input logic [7:0] token_byte,
  input logic       token_end,
  input logic       method_valid,
  input logic       method_stall,
  input logic [3:0] method_code
);

  `SIPM_ASSERT_NOW(a_code_range, method_valid, method_code <= 4'd10, "method code out of range")

  `SIPM_ASSERT_NOW(a_stall_only_on_held_result, token_stall, method_valid && method_stall, "byte stalled with no held result")

  `SIPM_ASSERT_NOW(a_result_from_final_byte, $rose(method_valid), $past(token_valid && !token_stall && token_end, 2), "result without a final byte two cycles before")

  `SIPM_ASSERT_NEXT(a_held_result_stable, method_valid && method_stall, method_valid && $stable(method_code), "held result changed")

endmodule

bind sip_method_keyword_matcher sipm_checker u_checker (.*);
